// ===== rtl/scap_pkg.sv =====
// Shared types and constants for the size-class pool allocator.
// Holds the class layout tables, result status codes and controller states.
// No dependencies.
package scap_pkg;

    localparam int MAX_CLASSES  = 7;
    localparam int TOTAL_BLOCKS = 6144;
    localparam int BIT_IDX_W    = 13;
    localparam int OFFSET_W     = 21;
    localparam int SIZE_W       = 16;
    localparam int CLASS_W      = 3;
    localparam int BLK_IDX_W    = 11;

    localparam logic [SIZE_W-1:0] MAX_REQ = 16'd1024;

    typedef logic [BIT_IDX_W-1:0] t_bit_idx;
    typedef logic [OFFSET_W-1:0]  t_offset;
    typedef logic [CLASS_W-1:0]   t_class;

    // First use bit of each class; the last entry is the end of the map.
    localparam t_bit_idx CLASS_BIT_BASE [0:MAX_CLASSES] = '{
        13'd0, 13'd2048, 13'd3072, 13'd3584, 13'd4608, 13'd5120, 13'd5632, 13'd6144
    };

    // First byte of each class; the last entry is the end of the pool.
    localparam t_offset CLASS_BYTE_BASE [0:MAX_CLASSES] = '{
        21'd0, 21'd32768, 21'd65536, 21'd98304, 21'd229376, 21'd360448,
        21'd622592, 21'd1146880
    };

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_OVERSIZE    = 3'd1,
        STAT_EXHAUSTED   = 3'd2,
        STAT_RANGE       = 3'd3,
        STAT_DOUBLE_FREE = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_ALLOC_OUT,
        S_FREE_MUL,
        S_FREE_REM,
        S_FREE_RD,
        S_FREE_CHK
    } t_state;

endpackage

// ===== rtl/size_class_pool_allocator_top.sv =====
// Top level of the size-class pool allocator: controller, decode and free-bit arithmetic.
// Depends on scap_pkg, scap_map_ram and scap_word_find.
//
//   Channel   Handshake          Fields
//   --------  -----------------  ------------------------------------------
//   request   start / busy       i_op, i_req_size, i_free_offset
//   result    o_valid (strobe)   o_status, o_block_offset, o_size_class
//
// After reset the use map is cleared one word per cycle, MAP_DEPTH words in all
// (96 at the default word width), with busy held high.
// An allocate scans the map words of its class, reading one word per cycle from the
// map memory. A free passes through the multiply, remainder, read and check states.
// An oversize request or an out-of-range free is answered from the decode state.
// The result strobe is high for one cycle and cannot be held off; busy falls in
// that same cycle, so the next item may be started while a result is shown.
module size_class_pool_allocator_top
    import scap_pkg::*;
#(
    parameter int MAP_WORD_BITS = 64,
    parameter int CLASS_NUMBER  = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic          i_op,
    input  logic [15:0]   i_req_size,
    input  logic [20:0]   i_free_offset,
    output logic          o_valid,
    output logic [2:0]    o_status,
    output logic [20:0]   o_block_offset,
    output logic [2:0]    o_size_class
);

    localparam int MAP_DEPTH   = (TOTAL_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW          = $clog2(MAP_DEPTH);
    localparam int BW          = $clog2(MAP_WORD_BITS);
    // Word number of a use bit is found by a reciprocal multiply; exact for 13-bit indexes.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 22;
    localparam int PROD_W      = BIT_IDX_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((2 ** RECIP_SHIFT) + MAP_WORD_BITS - 1) / MAP_WORD_BITS);

    t_state r_state, n_state;

    // Latched request.
    logic                 r_op;
    logic [SIZE_W-1:0]    r_size;
    t_offset              r_off;

    // Class being worked on and free-path values.
    t_class               r_k;
    t_bit_idx             r_bit;
    t_offset              r_aligned;
    logic [PROD_W-1:0]    r_prod;
    logic [AW-1:0]        r_word;
    logic [BW-1:0]        r_sel;

    // Scan pipeline: read issue side and check side.
    logic [AW-1:0]        r_rd_addr;
    logic [AW-1:0]        r_end_addr;
    t_bit_idx             r_rd_wbit;
    t_bit_idx             r_lo;
    t_bit_idx             r_hi;
    logic                 r_issue_more;
    logic                 r_chk_vld;
    logic                 r_chk_last;
    logic [AW-1:0]        r_chk_addr;
    t_bit_idx             r_chk_wbit;
    logic [BLK_IDX_W-1:0] r_blk_idx;

    logic [AW-1:0]        r_clr_addr;

    // Result registers.
    logic                 r_valid;
    t_status              r_status;
    t_offset              r_block_offset;
    t_class               r_size_class;

    // Memory controls.
    logic                     w_wr_en;
    logic [AW-1:0]            w_wr_addr;
    logic [MAP_WORD_BITS-1:0] w_wr_data;
    logic                     w_rd_en;
    logic [AW-1:0]            w_rd_addr;
    logic [MAP_WORD_BITS-1:0] w_rd_data;

    logic                     w_found;
    logic [BW-1:0]            w_pos;

    // Per-class scan limits, worked out at elaboration.
    logic [AW-1:0] w_start_word [0:MAX_CLASSES-1];
    logic [AW-1:0] w_end_word   [0:MAX_CLASSES-1];
    t_bit_idx      w_start_wbit [0:MAX_CLASSES-1];

    for (genvar g = 0; g < MAX_CLASSES; g++) begin : g_class
        localparam int SW = int'(CLASS_BIT_BASE[g]) / MAP_WORD_BITS;
        localparam int EW = (int'(CLASS_BIT_BASE[g+1]) - 1) / MAP_WORD_BITS;
        assign w_start_word[g] = AW'(SW);
        assign w_end_word[g]   = AW'(EW);
        assign w_start_wbit[g] = BIT_IDX_W'(SW * MAP_WORD_BITS);
    end

    // Allocate decode: smallest class whose block holds the request.
    t_class w_size_k;
    logic   w_oversize;

    always_comb begin
        w_size_k = '0;
        for (int c = MAX_CLASSES - 1; c >= 0; c--) begin
            if (r_size <= SIZE_W'(16 << c)) begin
                w_size_k = CLASS_W'(c);
            end
        end
        w_oversize = (r_size > MAX_REQ) || (w_size_k >= CLASS_W'(CLASS_NUMBER));
    end

    // Free decode: class from the offset range, then the block's use bit.
    t_class   w_free_k;
    logic     w_free_oor;
    t_offset  w_free_rel;
    t_bit_idx w_free_bit;
    t_offset  w_free_aligned;

    always_comb begin
        w_free_k = '0;
        for (int c = MAX_CLASSES - 1; c >= 0; c--) begin
            if (c < CLASS_NUMBER && r_off < CLASS_BYTE_BASE[c+1]) begin
                w_free_k = CLASS_W'(c);
            end
        end
        w_free_oor     = (r_off >= CLASS_BYTE_BASE[CLASS_NUMBER]);
        w_free_rel     = (r_off - CLASS_BYTE_BASE[w_free_k]) >> (5'd4 + 5'(w_free_k));
        w_free_bit     = CLASS_BIT_BASE[w_free_k] + BIT_IDX_W'(w_free_rel[BLK_IDX_W-1:0]);
        w_free_aligned = r_off & ~((21'd16 << w_free_k) - 21'd1);
    end

    logic [BW-1:0] w_free_sel;
    logic [AW-1:0] w_free_word;

    always_comb begin
        w_free_word = r_prod[RECIP_SHIFT +: AW];
        w_free_sel  = BW'(r_bit - BIT_IDX_W'(BIT_IDX_W'(w_free_word) *
                                             BIT_IDX_W'(MAP_WORD_BITS)));
    end

    t_bit_idx w_hit_bit;
    assign w_hit_bit = r_chk_wbit + BIT_IDX_W'(w_pos) - r_lo;

    scap_map_ram #(
        .WORD_BITS (MAP_WORD_BITS),
        .DEPTH     (MAP_DEPTH),
        .AW        (AW)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    scap_word_find #(
        .WORD_BITS (MAP_WORD_BITS),
        .BW        (BW)
    ) u_find (
        .i_word     (w_rd_data),
        .i_word_bit (r_chk_wbit),
        .i_lo       (r_lo),
        .i_hi       (r_hi),
        .o_found    (w_found),
        .o_pos      (w_pos)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(MAP_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_op == OP_ALLOC) begin
                    n_state = w_oversize ? S_IDLE : S_SCAN;
                end else begin
                    n_state = w_free_oor ? S_IDLE : S_FREE_MUL;
                end
            end
            S_SCAN: begin
                if (r_chk_vld && w_found) begin
                    n_state = S_ALLOC_OUT;
                end else if (r_chk_vld && r_chk_last) begin
                    n_state = S_IDLE;
                end
            end
            S_ALLOC_OUT: n_state = S_IDLE;
            S_FREE_MUL:  n_state = S_FREE_REM;
            S_FREE_REM:  n_state = S_FREE_RD;
            S_FREE_RD:   n_state = S_FREE_CHK;
            S_FREE_CHK:  n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Memory and handshake controls.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_chk_addr;
        w_wr_data = w_rd_data;
        w_rd_en   = 1'b0;
        w_rd_addr = r_rd_addr;
        busy      = 1'b1;
        case (r_state)
            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr_addr;
                w_wr_data = '0;
            end
            S_IDLE: begin
                busy = 1'b0;
            end
            S_SCAN: begin
                w_rd_en   = r_issue_more;
                w_wr_en   = r_chk_vld && w_found;
                w_wr_data = w_rd_data | (MAP_WORD_BITS'(1) << w_pos);
            end
            S_FREE_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_word;
            end
            S_FREE_CHK: begin
                w_wr_en   = w_rd_data[r_sel];
                w_wr_addr = r_word;
                w_wr_data = w_rd_data & ~(MAP_WORD_BITS'(1) << r_sel);
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_valid      <= 1'b0;
            r_issue_more <= 1'b0;
            r_chk_vld    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                end
                S_DECODE: begin
                    r_issue_more <= (r_op == OP_ALLOC) && !w_oversize;
                    r_chk_vld    <= 1'b0;
                    r_valid      <= (r_op == OP_ALLOC) ? w_oversize : w_free_oor;
                end
                S_SCAN: begin
                    if (r_chk_vld && (w_found || r_chk_last)) begin
                        r_issue_more <= 1'b0;
                        r_chk_vld    <= 1'b0;
                        r_valid      <= !w_found;
                    end else begin
                        r_chk_vld <= r_issue_more;
                        if (r_issue_more && r_rd_addr == r_end_addr) begin
                            r_issue_more <= 1'b0;
                        end
                    end
                end
                S_ALLOC_OUT: r_valid <= 1'b1;
                S_FREE_CHK:  r_valid <= 1'b1;
                default: begin
                    r_valid <= 1'b0;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_op   <= i_op;
                    r_size <= i_req_size;
                    r_off  <= i_free_offset;
                end
            end
            S_DECODE: begin
                r_block_offset <= '0;
                r_size_class   <= '0;
                if (r_op == OP_ALLOC) begin
                    r_status   <= STAT_OVERSIZE;
                    r_k        <= w_size_k;
                    r_rd_addr  <= w_start_word[w_size_k];
                    r_end_addr <= w_end_word[w_size_k];
                    r_rd_wbit  <= w_start_wbit[w_size_k];
                    r_lo       <= CLASS_BIT_BASE[w_size_k];
                    r_hi       <= CLASS_BIT_BASE[w_size_k + CLASS_W'(1)];
                end else begin
                    r_status  <= STAT_RANGE;
                    r_k       <= w_free_k;
                    r_bit     <= w_free_bit;
                    r_aligned <= w_free_aligned;
                end
            end
            S_SCAN: begin
                if (r_issue_more) begin
                    r_chk_addr <= r_rd_addr;
                    r_chk_wbit <= r_rd_wbit;
                    r_chk_last <= (r_rd_addr == r_end_addr);
                    r_rd_addr  <= r_rd_addr + AW'(1);
                    r_rd_wbit  <= r_rd_wbit + BIT_IDX_W'(MAP_WORD_BITS);
                end
                if (r_chk_vld && w_found) begin
                    r_blk_idx <= w_hit_bit[BLK_IDX_W-1:0];
                end else if (r_chk_vld && r_chk_last) begin
                    r_status       <= STAT_EXHAUSTED;
                    r_block_offset <= '0;
                    r_size_class   <= r_k;
                end
            end
            S_ALLOC_OUT: begin
                r_status       <= STAT_OK;
                r_block_offset <= CLASS_BYTE_BASE[r_k] +
                                  (OFFSET_W'(r_blk_idx) << (5'd4 + 5'(r_k)));
                r_size_class   <= r_k;
            end
            S_FREE_MUL: begin
                r_prod <= PROD_W'(r_bit) * PROD_W'(RECIP);
            end
            S_FREE_REM: begin
                r_word <= w_free_word;
                r_sel  <= w_free_sel;
            end
            S_FREE_CHK: begin
                r_size_class <= r_k;
                if (w_rd_data[r_sel]) begin
                    r_status       <= STAT_OK;
                    r_block_offset <= r_aligned;
                end else begin
                    r_status       <= STAT_DOUBLE_FREE;
                    r_block_offset <= '0;
                end
            end
            default: begin
                r_op <= r_op;
            end
        endcase
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_block_offset = r_block_offset;
    assign o_size_class   = r_size_class;

    // The map is only written while an item or the clearing pass is in progress.
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !w_wr_en)
        else $error("map written while idle");

    // The scan never reads the word it is writing back in the same cycle.
    a_no_rw_same_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en && w_wr_en |-> w_rd_addr != w_wr_addr)
        else $error("read and write hit the same map word");

    // A started item keeps the block busy on the following cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("block not busy after an item was started");

    // A successful result always names a block inside the existing classes.
    a_ok_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status == STAT_OK |->
            r_block_offset < CLASS_BYTE_BASE[CLASS_NUMBER] &&
            r_size_class < CLASS_W'(CLASS_NUMBER))
        else $error("result block outside the pool");

    // A result strobe only follows work on an item, never the clearing pass.
    a_valid_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state) != S_CLEAR && $past(r_state) != S_IDLE)
        else $error("result strobe without an item");

endmodule

// ===== rtl/scap_map_ram.sv =====
// Use-map memory: one write port and one read port with registered read data.
// Depends on nothing but its parameters.
module scap_map_ram #(
    parameter int WORD_BITS = 64,
    parameter int DEPTH     = 96,
    parameter int AW        = 7
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [WORD_BITS-1:0] i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [WORD_BITS-1:0] o_rd_data
);

    logic [WORD_BITS-1:0] r_mem [0:DEPTH-1];
    logic [WORD_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/scap_word_find.sv =====
// Finds the lowest free use bit of one map word that belongs to the class being scanned.
// Depends on scap_pkg for the bit index type.
module scap_word_find
    import scap_pkg::*;
#(
    parameter int WORD_BITS = 64,
    parameter int BW        = 6
) (
    input  logic [WORD_BITS-1:0] i_word,
    input  t_bit_idx             i_word_bit,
    input  t_bit_idx             i_lo,
    input  t_bit_idx             i_hi,
    output logic                 o_found,
    output logic [BW-1:0]        o_pos
);

    logic [WORD_BITS-1:0] w_avail;

    // A bit is a candidate when it is clear and its global index lies in the class.
    always_comb begin
        t_bit_idx v_idx;
        for (int j = 0; j < WORD_BITS; j++) begin
            v_idx      = i_word_bit + BIT_IDX_W'(j);
            w_avail[j] = !i_word[j] && (v_idx >= i_lo) && (v_idx < i_hi);
        end
    end

    always_comb begin
        o_found = 1'b0;
        o_pos   = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (w_avail[j]) begin
                o_found = 1'b1;
                o_pos   = BW'(j);
            end
        end
    end

endmodule
